// File: hdl/rlbs_pkg.sv
// Shared types, constants and codes for the RGB LED breathing serialiser.
`timescale 1ns / 1ps
`default_nettype none

package rlbs_pkg;

   // field widths
   localparam int COLOR_W  = 8;
   localparam int LEVEL_W  = 7;
   localparam int TICK_W   = 15;
   localparam int OP_W     = 2;
   localparam int CSR_IDX_W = 3;
   localparam int FRAME_W  = 3 * COLOR_W;

   // brightness stepping
   localparam logic [LEVEL_W-1:0] FULL_PCT = LEVEL_W'(100);
   localparam logic [LEVEL_W-1:0] STEP_PCT = LEVEL_W'(5);

   // x / 100 as (x * 5243) >> 19, exact for x below 43699
   localparam int PROD_W      = COLOR_W + LEVEL_W;
   localparam int RECIP_W     = 13;
   localparam int RECIP_SHIFT = 19;
   localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);

   // symbols in one frame: 24 data bits and one latch symbol
   localparam int SYMBOLS = FRAME_W + 1;
   localparam int SYM_CNT_W = $clog2(SYMBOLS);

   // default queue depth between front and back
   localparam int QUEUE_DEPTH_DEF = 4;

   // reset values of the timing registers
   localparam logic [TICK_W-1:0] ZERO_HIGH_RST  = TICK_W'(3);
   localparam logic [TICK_W-1:0] ZERO_LOW_RST   = TICK_W'(10);
   localparam logic [TICK_W-1:0] ONE_HIGH_RST   = TICK_W'(10);
   localparam logic [TICK_W-1:0] ONE_LOW_RST    = TICK_W'(3);
   localparam logic [TICK_W-1:0] LATCH_HALF_RST = TICK_W'(2800);

   typedef enum logic [OP_W-1:0] {
      OP_SET_COLOR   = 2'd0,
      OP_START_PULSE = 2'd1,
      OP_PULSE_STEP  = 2'd2
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ZERO_HIGH  = 3'd0,
      CSR_ZERO_LOW   = 3'd1,
      CSR_ONE_HIGH   = 3'd2,
      CSR_ONE_LOW    = 3'd3,
      CSR_LATCH_HALF = 3'd4
   } csr_idx_type;

   // one colour frame, sent green, red, blue
   typedef struct packed {
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] blue;
   } frame_type;

   // head of the frame queue as the back end sees it
   typedef struct packed {
      logic      valid;
      frame_type frame;
   } q_head_type;

endpackage

`default_nettype wire

// File: hdl/rlbs_queue.sv
// Small frame queue between the front end and the serialiser.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_queue #(
   parameter int QUEUE_DEPTH = rlbs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             push,
   input  wire rlbs_pkg::frame_type              push_frame,
   input  wire logic                             pop,
   output rlbs_pkg::q_head_type                  head,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0]      count
);
   import rlbs_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   frame_type          slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_pop;

   assign do_pop = pop && (count_ff != '0);

   // pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_frame;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.frame = slot_ff[rd_ptr_ff];
   assign count      = count_ff;

endmodule

`default_nettype wire

// File: hdl/rlbs_front.sv
// Front end: takes items, keeps colour and breathing state, scales frames.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_front #(
   parameter int QUEUE_DEPTH = rlbs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_push,
   output logic                                   req_full,
   input  wire logic [rlbs_pkg::OP_W-1:0]         req_op,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]      req_red,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]      req_green,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]      req_blue,
   input  wire logic [$clog2(QUEUE_DEPTH+1)-1:0]  q_count,
   output logic                                   q_push,
   output rlbs_pkg::frame_type                    q_frame
);
   import rlbs_pkg::*;

   localparam int CNT_W   = $clog2(QUEUE_DEPTH + 1);
   localparam int SCALE_W = PROD_W + RECIP_W;

   // held state
   logic [COLOR_W-1:0] red_ff, red_in;
   logic [COLOR_W-1:0] green_ff, green_in;
   logic [COLOR_W-1:0] blue_ff, blue_in;
   logic               pulsing_ff, pulsing_in;
   logic [LEVEL_W-1:0] level_ff, level_in;
   logic               rising_ff, rising_in;

   // scaling pipeline
   logic               s1_valid_ff, s1_valid_in;
   logic [PROD_W-1:0]  s1_red_ff, s1_green_ff, s1_blue_ff;
   logic               s2_valid_ff;
   frame_type          s2_frame_ff;

   logic               accept;
   logic               s1_load;
   logic [COLOR_W-1:0] mul_red, mul_green, mul_blue;
   logic [LEVEL_W-1:0] mul_level;
   logic [LEVEL_W-1:0] level_up;
   logic [CNT_W:0]     credits;
   logic [SCALE_W-1:0] sc_red, sc_green, sc_blue;

   // every frame in flight holds a queue slot, so the queue never overflows
   assign credits  = (CNT_W+1)'(q_count) + (CNT_W+1)'(s1_valid_ff)
                   + (CNT_W+1)'(s2_valid_ff);
   assign req_full = (credits >= (CNT_W+1)'(QUEUE_DEPTH));
   assign accept   = req_push && !req_full;
   assign level_up = level_ff + STEP_PCT;

   // decode the item and work out the next state
   always_comb begin
      red_in     = red_ff;
      green_in   = green_ff;
      blue_in    = blue_ff;
      pulsing_in = pulsing_ff;
      level_in   = level_ff;
      rising_in  = rising_ff;
      mul_red    = red_ff;
      mul_green  = green_ff;
      mul_blue   = blue_ff;
      mul_level  = level_ff;
      s1_load    = 1'b0;
      if (accept) begin
         case (op_type'(req_op))
            OP_SET_COLOR: begin
               red_in     = req_red;
               green_in   = req_green;
               blue_in    = req_blue;
               pulsing_in = 1'b0;
               // full scale: colour * 100 / 100 gives the colour back
               mul_red    = req_red;
               mul_green  = req_green;
               mul_blue   = req_blue;
               mul_level  = FULL_PCT;
               s1_load    = 1'b1;
            end
            OP_START_PULSE: begin
               red_in     = req_red;
               green_in   = req_green;
               blue_in    = req_blue;
               pulsing_in = 1'b1;
            end
            OP_PULSE_STEP: begin
               if (pulsing_ff) begin
                  s1_load = 1'b1;
                  if (rising_ff) begin
                     if (level_up >= FULL_PCT) begin
                        level_in  = FULL_PCT;
                        rising_in = 1'b0;
                     end else begin
                        level_in = level_up;
                     end
                  end else begin
                     if (level_ff <= STEP_PCT) begin
                        level_in  = '0;
                        rising_in = 1'b1;
                     end else begin
                        level_in = level_ff - STEP_PCT;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
      s1_valid_in = s1_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff      <= '0;
         green_ff    <= '0;
         blue_ff     <= '0;
         pulsing_ff  <= 1'b0;
         level_ff    <= '0;
         rising_ff   <= 1'b1;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         pulsing_ff  <= pulsing_in;
         level_ff    <= level_in;
         rising_ff   <= rising_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   // stage 1: colour times level
   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_red_ff   <= PROD_W'(mul_red) * PROD_W'(mul_level);
         s1_green_ff <= PROD_W'(mul_green) * PROD_W'(mul_level);
         s1_blue_ff  <= PROD_W'(mul_blue) * PROD_W'(mul_level);
      end
   end

   // stage 2: divide by 100 through the reciprocal
   assign sc_red   = SCALE_W'(s1_red_ff) * SCALE_W'(RECIP_100);
   assign sc_green = SCALE_W'(s1_green_ff) * SCALE_W'(RECIP_100);
   assign sc_blue  = SCALE_W'(s1_blue_ff) * SCALE_W'(RECIP_100);

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_frame_ff.red   <= sc_red[RECIP_SHIFT +: COLOR_W];
         s2_frame_ff.green <= sc_green[RECIP_SHIFT +: COLOR_W];
         s2_frame_ff.blue  <= sc_blue[RECIP_SHIFT +: COLOR_W];
      end
   end

   assign q_push  = s2_valid_ff;
   assign q_frame = s2_frame_ff;

endmodule

`default_nettype wire

// File: hdl/rlbs_back.sv
// Back end: timing registers and the symbol serialiser with its result register.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rlbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rlbs_pkg::TICK_W-1:0]     csr_data,
   input  wire rlbs_pkg::q_head_type            q_head,
   output logic                                 q_pop,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_first_level,
   output logic [rlbs_pkg::TICK_W-1:0]          rsp_first_ticks,
   output logic [rlbs_pkg::TICK_W-1:0]          rsp_second_ticks,
   output logic                                 rsp_frame_end
);
   import rlbs_pkg::*;

   localparam logic [SYM_CNT_W-1:0] LAST_SYM = SYM_CNT_W'(SYMBOLS - 1);

   // timing registers
   logic [TICK_W-1:0] zero_high_ff, zero_low_ff, one_high_ff, one_low_ff, latch_half_ff;

   // serialiser
   logic                 busy_ff, busy_in;
   logic [SYM_CNT_W-1:0] sym_ff, sym_in;
   logic [FRAME_W-1:0]   shift_ff, shift_in;

   // result register
   logic              out_valid_ff, out_valid_in;
   logic              out_level_ff, out_level_in;
   logic [TICK_W-1:0] out_first_ff, out_first_in;
   logic [TICK_W-1:0] out_second_ff, out_second_in;
   logic              out_end_ff, out_end_in;

   logic advance;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         zero_high_ff  <= ZERO_HIGH_RST;
         zero_low_ff   <= ZERO_LOW_RST;
         one_high_ff   <= ONE_HIGH_RST;
         one_low_ff    <= ONE_LOW_RST;
         latch_half_ff <= LATCH_HALF_RST;
      end else if (csr_valid) begin
         case (csr_idx_type'(csr_index))
            CSR_ZERO_HIGH:  zero_high_ff  <= csr_data;
            CSR_ZERO_LOW:   zero_low_ff   <= csr_data;
            CSR_ONE_HIGH:   one_high_ff   <= csr_data;
            CSR_ONE_LOW:    one_low_ff    <= csr_data;
            CSR_LATCH_HALF: latch_half_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   // result slot is free or being taken this cycle
   assign advance = !out_valid_ff || rsp_pop;

   // one symbol per cycle unless stalled; next frame loads with the latch symbol
   always_comb begin
      busy_in       = busy_ff;
      sym_in        = sym_ff;
      shift_in      = shift_ff;
      out_valid_in  = out_valid_ff;
      out_level_in  = out_level_ff;
      out_first_in  = out_first_ff;
      out_second_in = out_second_ff;
      out_end_in    = out_end_ff;
      q_pop         = 1'b0;
      if (advance) begin
         out_valid_in = busy_ff;
      end
      if (busy_ff) begin
         if (advance) begin
            if (sym_ff == LAST_SYM) begin
               out_level_in  = 1'b0;
               out_first_in  = latch_half_ff;
               out_second_in = latch_half_ff;
               out_end_in    = 1'b1;
               busy_in       = q_head.valid;
               q_pop         = q_head.valid;
               sym_in        = '0;
               shift_in      = q_head.frame;
            end else begin
               out_level_in  = 1'b1;
               out_first_in  = shift_ff[FRAME_W-1] ? one_high_ff : zero_high_ff;
               out_second_in = shift_ff[FRAME_W-1] ? one_low_ff : zero_low_ff;
               out_end_in    = 1'b0;
               sym_in        = sym_ff + SYM_CNT_W'(1);
               shift_in      = {shift_ff[FRAME_W-2:0], 1'b0};
            end
         end
      end else if (q_head.valid) begin
         busy_in  = 1'b1;
         q_pop    = 1'b1;
         sym_in   = '0;
         shift_in = q_head.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         sym_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         sym_ff       <= sym_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff      <= shift_in;
      out_level_ff  <= out_level_in;
      out_first_ff  <= out_first_in;
      out_second_ff <= out_second_in;
      out_end_ff    <= out_end_in;
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_first_level  = out_level_ff;
   assign rsp_first_ticks  = out_first_ff;
   assign rsp_second_ticks = out_second_ff;
   assign rsp_frame_end    = out_end_ff;

endmodule

`default_nettype wire

// File: hdl/rgb_led_breathing_serializer.sv
// Top level of the RGB LED breathing serialiser.
`timescale 1ns / 1ps
`default_nettype none

// Drives one addressable RGB LED as a stream of line symbols (high ticks, low
// ticks). set_color sends the colour as 24 data symbols, green, red, blue, MSB
// first, then one latch symbol; start_pulse stores a colour and enables
// breathing; each pulse_step then sends the colour scaled by the brightness
// level and moves the level 5 % up or down between 0 and 100. Items are taken
// one per cycle while req_full is low; a colour item passes a two-stage scaling
// pipeline into a queue of QUEUE_DEPTH frames, and req_full rises once frames
// in the pipeline and the queue fill that queue. The serialiser puts out one
// symbol per cycle while results are taken, so the 25 symbols of each frame
// set the sustained rate of frame items. Each frame passes both scaling stages,
// the queue and the shift register before its first symbol is put out. Timing
// registers should be written while the block is idle; csr_ready is always high.
module rgb_led_breathing_serializer #(
   parameter int QUEUE_DEPTH = rlbs_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_push,
   output logic                                 req_full,
   input  wire logic [rlbs_pkg::OP_W-1:0]       req_op,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]    req_red,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]    req_green,
   input  wire logic [rlbs_pkg::COLOR_W-1:0]    req_blue,
   output logic                                 rsp_empty,
   input  wire logic                            rsp_pop,
   output logic                                 rsp_first_level,
   output logic [rlbs_pkg::TICK_W-1:0]          rsp_first_ticks,
   output logic [rlbs_pkg::TICK_W-1:0]          rsp_second_ticks,
   output logic                                 rsp_frame_end,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [rlbs_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [rlbs_pkg::TICK_W-1:0]     csr_data
);
   import rlbs_pkg::*;

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic             q_push;
   frame_type        q_frame;
   logic             q_pop;
   q_head_type       q_head;
   logic [CNT_W-1:0] q_count;

   rlbs_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_op    (req_op),
      .req_red   (req_red),
      .req_green (req_green),
      .req_blue  (req_blue),
      .q_count   (q_count),
      .q_push    (q_push),
      .q_frame   (q_frame)
   );

   rlbs_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_frame (q_frame),
      .pop        (q_pop),
      .head       (q_head),
      .count      (q_count)
   );

   rlbs_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_first_level  (rsp_first_level),
      .rsp_first_ticks  (rsp_first_ticks),
      .rsp_second_ticks (rsp_second_ticks),
      .rsp_frame_end    (rsp_frame_end)
   );

endmodule

`default_nettype wire

// File: hdl/rlbs_checker.sv
// Port-level checks for the RGB LED breathing serialiser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module rlbs_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_full,
   input wire logic                            rsp_empty,
   input wire logic                            rsp_pop,
   input wire logic                            rsp_first_level,
   input wire logic [rlbs_pkg::TICK_W-1:0]     rsp_first_ticks,
   input wire logic [rlbs_pkg::TICK_W-1:0]     rsp_second_ticks,
   input wire logic                            rsp_frame_end
);

   // after reset nothing is waiting and the input side is open
   a_reset_clears : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("result or full flag set after reset");

   // a waiting result holds until it is taken
   a_rsp_holds : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_first_level)
         && $stable(rsp_first_ticks) && $stable(rsp_second_ticks)
         && $stable(rsp_frame_end))
      else $error("waiting result changed before it was taken");

   // the latch symbol is low with two equal halves
   a_latch_shape : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && rsp_frame_end |-> !rsp_first_level
         && (rsp_first_ticks == rsp_second_ticks))
      else $error("latch symbol malformed");

   // every symbol is either a data bit or the latch, never both or neither
   a_symbol_kind : assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_first_level != rsp_frame_end))
      else $error("symbol neither data bit nor latch");

endmodule

bind rgb_led_breathing_serializer rlbs_checker u_rlbs_checker (.*);

`default_nettype wire

// File: tb/sv/rgb_led_breathing_serializer_checker.sv
// Checker for the RGB LED serialiser: predicts the symbol stream and compares each result.
`timescale 1ns / 1ps

module rgb_led_breathing_serializer_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic [rlbs_pkg::OP_W-1:0]      req_op,
   input  logic [rlbs_pkg::COLOR_W-1:0]   req_red,
   input  logic [rlbs_pkg::COLOR_W-1:0]   req_green,
   input  logic [rlbs_pkg::COLOR_W-1:0]   req_blue,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic                           rsp_first_level,
   input  logic [rlbs_pkg::TICK_W-1:0]    rsp_first_ticks,
   input  logic [rlbs_pkg::TICK_W-1:0]    rsp_second_ticks,
   input  logic                           rsp_frame_end,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [rlbs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rlbs_pkg::TICK_W-1:0]    csr_data,
   output int                             mismatches,
   output int                             outstanding
);
   import rlbs_pkg::*;

   // one line symbol as it leaves the block
   typedef struct packed {
      logic              first_level;
      logic [TICK_W-1:0] first_ticks;
      logic [TICK_W-1:0] second_ticks;
      logic              frame_end;
   } symbol_type;

   // timing registers
   logic [TICK_W-1:0]  zero_hi, zero_lo, one_hi, one_lo, latch_half;
   // colour and breathing state
   logic [COLOR_W-1:0] keep_red, keep_green, keep_blue;
   logic [LEVEL_W-1:0] bright;
   logic               breathing, climbing;

   symbol_type         symbols_due[$];
   symbol_type         seen, due;
   int                 fail_count;

   // colour channel scaled by brightness percentage, integer division
   function automatic logic [COLOR_W-1:0] dim(input logic [COLOR_W-1:0] c,
                                              input logic [LEVEL_W-1:0] pct);
      int prod;
      prod = int'(c) * int'(pct);
      return COLOR_W'(prod / int'(FULL_PCT));
   endfunction

   // 24 data symbols, green red blue, MSB first, then the latch symbol
   task automatic queue_frame(input logic [COLOR_W-1:0] r, input logic [COLOR_W-1:0] g,
                              input logic [COLOR_W-1:0] b);
      logic [FRAME_W-1:0] bits;
      symbol_type         s;
      bits = {g, r, b};
      for (int i = FRAME_W - 1; i >= 0; i--) begin
         s.first_level = 1'b1;
         s.frame_end   = 1'b0;
         if (bits[i]) begin
            s.first_ticks  = one_hi;
            s.second_ticks = one_lo;
         end else begin
            s.first_ticks  = zero_hi;
            s.second_ticks = zero_lo;
         end
         symbols_due.push_back(s);
      end
      s.first_level  = 1'b0;
      s.first_ticks  = latch_half;
      s.second_ticks = latch_half;
      s.frame_end    = 1'b1;
      symbols_due.push_back(s);
   endtask

   // brightness walks 0..100 in steps of 5, turning round at each end
   task automatic step_brightness();
      if (climbing) begin
         if (bright + STEP_PCT >= FULL_PCT) begin
            bright   = FULL_PCT;
            climbing = 1'b0;
         end else begin
            bright = bright + STEP_PCT;
         end
      end else begin
         if (bright <= STEP_PCT) begin
            bright   = '0;
            climbing = 1'b1;
         end else begin
            bright = bright - STEP_PCT;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         zero_hi    = ZERO_HIGH_RST;
         zero_lo    = ZERO_LOW_RST;
         one_hi     = ONE_HIGH_RST;
         one_lo     = ONE_LOW_RST;
         latch_half = LATCH_HALF_RST;
         keep_red   = '0;
         keep_green = '0;
         keep_blue  = '0;
         bright     = '0;
         breathing  = 1'b0;
         climbing   = 1'b1;
         symbols_due.delete();
      end else begin
         // register write; indexes past the list are dropped
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ZERO_HIGH:  zero_hi    = csr_data;
               CSR_ZERO_LOW:   zero_lo    = csr_data;
               CSR_ONE_HIGH:   one_hi     = csr_data;
               CSR_ONE_LOW:    one_lo     = csr_data;
               CSR_LATCH_HALF: latch_half = csr_data;
               default: ;
            endcase
         end

         // result against the oldest expectation
         if (rsp_pop && !rsp_empty) begin
            seen = '{rsp_first_level, rsp_first_ticks, rsp_second_ticks, rsp_frame_end};
            if (symbols_due.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected symbol level %0d first %0d second %0d end %0d",
                           $realtime, seen.first_level, seen.first_ticks,
                           seen.second_ticks, seen.frame_end);
            end else begin
               due = symbols_due.pop_front();
               if (seen.first_level !== due.first_level ||
                   seen.first_ticks !== due.first_ticks ||
                   seen.second_ticks !== due.second_ticks ||
                   seen.frame_end !== due.frame_end) begin
                  fail_count++;
                  // values as level, first ticks, second ticks, frame end
                  if (fail_count <= 10)
                     $display("%0t: symbol expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                              $realtime, due.first_level, due.first_ticks,
                              due.second_ticks, due.frame_end, seen.first_level,
                              seen.first_ticks, seen.second_ticks, seen.frame_end);
               end
            end
         end

         // accepted item
         if (req_push && !req_full) begin
            if (req_op == OP_SET_COLOR) begin
               breathing  = 1'b0;
               keep_red   = req_red;
               keep_green = req_green;
               keep_blue  = req_blue;
               queue_frame(req_red, req_green, req_blue);
            end else if (req_op == OP_START_PULSE) begin
               keep_red   = req_red;
               keep_green = req_green;
               keep_blue  = req_blue;
               breathing  = 1'b1;
            end else if (req_op == OP_PULSE_STEP && breathing) begin
               queue_frame(dim(keep_red, bright), dim(keep_green, bright),
                           dim(keep_blue, bright));
               step_brightness();
            end
         end
      end
      mismatches  <= fail_count;
      outstanding <= symbols_due.size();
   end

endmodule

// File: tb/sv/rgb_led_breathing_serializer_test.sv
// Testbench top for the RGB LED serialiser: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module rgb_led_breathing_serializer_test;
   import rlbs_pkg::*;

   // op code the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED = '1;
   // cycles allowed for the pipeline to settle once nothing is due
   localparam int DRAIN_CYCLES = 40;

   logic                 clock;
   logic                 reset;
   logic                 req_push;
   logic                 req_full;
   logic [OP_W-1:0]      req_op;
   logic [COLOR_W-1:0]   req_red, req_green, req_blue;
   logic                 rsp_empty;
   logic                 rsp_pop;
   logic                 rsp_first_level;
   logic [TICK_W-1:0]    rsp_first_ticks, rsp_second_ticks;
   logic                 rsp_frame_end;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [TICK_W-1:0]    csr_data;
   int                   mismatches, outstanding;
   bit                   send_steady, take_steady;

   rgb_led_breathing_serializer uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_op(req_op),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_first_level(rsp_first_level),
      .rsp_first_ticks(rsp_first_ticks), .rsp_second_ticks(rsp_second_ticks),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   rgb_led_breathing_serializer_checker u_checker (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_op(req_op),
      .req_red(req_red), .req_green(req_green), .req_blue(req_blue),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_first_level(rsp_first_level),
      .rsp_first_ticks(rsp_first_ticks), .rsp_second_ticks(rsp_second_ticks),
      .rsp_frame_end(rsp_frame_end),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data),
      .mismatches(mismatches), .outstanding(outstanding)
   );

   // 10 ns clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #6000000;
      $display("simulation failed");
      $finish;
   end

   // idle cycles per item, none during a steady stretch
   function automatic int draw_gap(input bit steady);
      return steady ? 0 : $urandom_range(0, 9);
   endfunction

   // colour channel biased towards the extremes
   function automatic logic [COLOR_W-1:0] rand_color();
      case ($urandom_range(0, 3))
         0:       return '0;
         1:       return '1;
         default: return COLOR_W'($urandom);
      endcase
   endfunction

   // result side: pop with random stalls for the whole run
   initial begin
      int gap;
      rsp_pop <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) take_steady = !take_steady;
         gap = draw_gap(take_steady);
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         @(posedge clock);
         while (rsp_empty) @(posedge clock);
      end
   end

   // one item; push is left high when the next item follows at once
   task automatic send_item(input logic [OP_W-1:0] op, input logic [COLOR_W-1:0] r,
                            input logic [COLOR_W-1:0] g, input logic [COLOR_W-1:0] b);
      int gap;
      req_push  <= 1'b1;
      req_op    <= op;
      req_red   <= r;
      req_green <= g;
      req_blue  <= b;
      @(posedge clock);
      while (req_full) @(posedge clock);
      if ($urandom_range(0, 39) == 0) send_steady = !send_steady;
      gap = draw_gap(send_steady);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender stops, then waits for every due symbol and the pipeline to drain
   task automatic wait_idle();
      req_push <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // all five timing registers, then the unused indexes
   task automatic write_timing(input logic [TICK_W-1:0] zh, input logic [TICK_W-1:0] zl,
                               input logic [TICK_W-1:0] oh, input logic [TICK_W-1:0] ol,
                               input logic [TICK_W-1:0] lh);
      write_reg(CSR_ZERO_HIGH, zh);
      write_reg(CSR_ZERO_LOW, zl);
      write_reg(CSR_ONE_HIGH, oh);
      write_reg(CSR_ONE_LOW, ol);
      write_reg(CSR_LATCH_HALF, lh);
      for (int k = int'(CSR_LATCH_HALF) + 1; k < 2 ** CSR_IDX_W; k++)
         write_reg(CSR_IDX_W'(k), TICK_W'($urandom));
   endtask

   // mostly breathing runs, some plain colours, some stray steps and junk ops
   task automatic run_random(input int target);
      int  sent, kind, steps;
      bit  paused;
      sent   = 0;
      paused = 1'b0;
      while (sent < target) begin
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            send_item(OP_START_PULSE, rand_color(), rand_color(), rand_color());
            sent++;
            steps = $urandom_range(1, 30);
            for (int k = 0; k < steps; k++) begin
               send_item(OP_PULSE_STEP, COLOR_W'($urandom), COLOR_W'($urandom),
                         COLOR_W'($urandom));
               sent++;
            end
         end else if (kind < 8) begin
            send_item(OP_SET_COLOR, rand_color(), rand_color(), rand_color());
            sent++;
         end else if (kind == 8) begin
            send_item(OP_PULSE_STEP, COLOR_W'($urandom), COLOR_W'($urandom),
                      COLOR_W'($urandom));
            sent++;
         end else begin
            send_item(OP_UNUSED, COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
         end
         // hold off halfway until everything has drained
         if (!paused && sent >= target / 2) begin
            wait_idle();
            paused = 1'b1;
         end
      end
      wait_idle();
   endtask

   // main sequence
   initial begin
      reset     <= 1'b1;
      req_push  <= 1'b0;
      req_op    <= OP_SET_COLOR;
      req_red   <= '0;
      req_green <= '0;
      req_blue  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_ZERO_HIGH;
      csr_data  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed items at reset timing
      send_item(OP_SET_COLOR, 8'h00, 8'h00, 8'h00);
      send_item(OP_SET_COLOR, 8'hff, 8'hff, 8'hff);
      send_item(OP_SET_COLOR, 8'h3c, 8'ha5, 8'h81);
      // step while breathing is off: nothing sent
      send_item(OP_PULSE_STEP, 8'hff, 8'hff, 8'hff);
      // unused op: ignored
      send_item(OP_UNUSED, 8'hff, 8'hff, 8'hff);
      send_item(OP_START_PULSE, 8'hff, 8'hff, 8'hff);
      send_item(OP_PULSE_STEP, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULSE_STEP, 8'h55, 8'haa, 8'h0f);
      send_item(OP_PULSE_STEP, 8'hf0, 8'h0f, 8'hff);
      // set colour stops breathing but keeps level and direction
      send_item(OP_SET_COLOR, 8'h12, 8'h34, 8'h56);
      send_item(OP_PULSE_STEP, 8'h00, 8'h00, 8'h00);
      // restart picks up at the kept level
      send_item(OP_START_PULSE, 8'h80, 8'h7f, 8'h01);
      send_item(OP_PULSE_STEP, 8'h00, 8'h00, 8'h00);
      send_item(OP_PULSE_STEP, 8'hff, 8'hff, 8'hff);
      send_item(OP_PULSE_STEP, 8'h00, 8'h00, 8'h00);
      wait_idle();

      // longest timings
      write_timing('1, '1, '1, '1, '1);
      run_random(115);
      // shortest timings
      write_timing('0, '0, '0, '0, '0);
      run_random(115);
      // random timings
      write_timing(TICK_W'($urandom), TICK_W'($urandom), TICK_W'($urandom),
                   TICK_W'($urandom), TICK_W'($urandom));
      run_random(115);
      // the usual line timing again, with a random latch length
      write_timing(ZERO_HIGH_RST, ZERO_LOW_RST, ONE_HIGH_RST, ONE_LOW_RST,
                   TICK_W'($urandom_range(1, 32766)));
      run_random(115);

      if (mismatches == 0 && outstanding == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

// File: sim.f
hdl/rlbs_pkg.sv
hdl/rlbs_queue.sv
hdl/rlbs_front.sv
hdl/rlbs_back.sv
hdl/rgb_led_breathing_serializer.sv
hdl/rlbs_checker.sv
tb/sv/rgb_led_breathing_serializer_checker.sv
tb/sv/rgb_led_breathing_serializer_test.sv
